// File: hdl/rsi_pkg.sv
// ---------------------------------------------------------------------------
// rsi_pkg: shared types for the ray-sphere intersection block
// Transfer payloads of the input and result channels, and output limits.
// ---------------------------------------------------------------------------
package rsi_pkg;

  // One test: ray origin, direction, current maximum distance, sphere
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] max_distance;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic        [30:0] radius;
  } rsi_in_t;

  // One result: hit flag and nearest distance
  typedef struct packed {
    logic               hit;
    logic signed [31:0] hit_distance;
  } rsi_out_t;

  // Root magnitude cap is 2^ROOT_CAP_LOG2
  localparam int ROOT_CAP_LOG2 = 62;

  // Saturation limits of hit_distance, held in 64 bits
  localparam logic signed [63:0] DIST_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] DIST_MIN = 64'shffff_ffff_8000_0000;

endpackage

// File: hdl/ray_sphere_intersect.sv
// ---------------------------------------------------------------------------
// ray_sphere_intersect: pipelined ray-sphere intersection test
// Forms a, h, c from dot products, takes the discriminant, its integer
// square root and both roots by restoring division, and keeps the nearest.
// ---------------------------------------------------------------------------
//
//   channel   handshake            payload     direction
//   -------   ------------------   ---------   ---------
//   in        in_valid / in_stall  in_data     into block
//   out       out_valid/ out_stall out_data    out of block
//
// One test enters per cycle while in_stall is low. The pipeline holds 6 setup
// stages, the discriminant stage, one stage per root bit of the square root
// (66 - FRAC_BITS), the q stage, 67 restoring division stages (both roots side
// by side), a root-select stage and the output reg.
// A skid register behind the output register takes one result when out_stall
// is high; while it is full the whole pipeline holds and in_stall is high.
// Reset clears valid bits only; the block keeps no state between tests.
// ---------------------------------------------------------------------------
module ray_sphere_intersect
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  rsi_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output rsi_out_t out_data
);

  localparam int F   = FRAC_BITS;
  localparam int AW  = 64 - F;       // a = D.D
  localparam int HW  = 66 - F;       // h = D.L, signed
  localparam int CW  = 67 - F;       // c = L.L - R*R, signed
  localparam int HMW = 65 - F;       // |h|
  localparam int CMW = 66 - F;       // |c|
  localparam int HH  = HMW - 32;     // upper split widths
  localparam int AH  = AW - 32;
  localparam int CH  = CMW - 32;
  localparam int DW  = 131 - 2 * F;  // discriminant
  localparam int SW  = 66 - F;       // square root bits
  localparam int QW  = 67 - F;       // |q| and division remainder
  localparam int NW  = QW + F;       // dividend and quotient bits
  localparam logic [NW-1:0] CAP_Q = NW'(1) << ROOT_CAP_LOG2;

  typedef struct packed {
    logic [HMW-1:0]     hm;
    logic               hpos;
    logic [CMW-1:0]     cm;
    logic               cneg;
    logic               czero;
    logic [AW-1:0]      a;
    logic               miss;
    logic               dzero;
    logic signed [31:0] tmax;
  } sq_side_t;

  typedef struct packed {
    logic               t0neg;
    logic               t1neg;
    logic               czero;
    logic               dzero;
    logic               miss;
    logic signed [31:0] tmax;
  } dv_side_t;

  logic adv;
  logic out_fire;

  // Stage registers
  logic               p1_v_r;
  logic signed [31:0] p1_d_r [3];
  logic signed [32:0] p1_l_r [3];
  logic [30:0]        p1_r_r;
  logic signed [31:0] p1_tmax_r;

  logic               p2_v_r;
  logic [62:0]        p2_dd_r [3];
  logic signed [64:0] p2_dl_r [3];
  logic [64:0]        p2_ll_r [3];
  logic [61:0]        p2_rr_r;
  logic signed [31:0] p2_tmax_r;

  logic               p3_v_r;
  logic [AW-1:0]      p3_a_r;
  logic signed [HW-1:0] p3_h_r;
  logic signed [CW-1:0] p3_c_r;
  logic signed [31:0] p3_tmax_r;

  logic               p4_v_r;
  sq_side_t           p4_side_r;

  logic               p5_v_r;
  sq_side_t           p5_side_r;
  logic [63:0]        p5_hll_r;
  logic [HMW-1:0]     p5_hlh_r;
  logic [2*HH-1:0]    p5_hhh_r;
  logic [63:0]        p5_all_r;
  logic [CMW-1:0]     p5_alh_r;
  logic [AW-1:0]      p5_ahl_r;
  logic [AH+CH-1:0]   p5_ahh_r;

  logic               p6_v_r;
  sq_side_t           p6_side_r;
  logic [DW-1:0]      p6_hh_r;
  logic [DW-1:0]      p6_ac_r;

  logic               sq_v_r    [SW+1];
  sq_side_t           sq_side_r [SW+1];
  logic [2*SW-1:0]    sq_rad_r  [SW+1];
  logic [SW+1:0]      sq_rem_r  [SW+1];
  logic [SW-1:0]      sq_root_r [SW+1];

  logic               dv_v_r    [NW+1];
  dv_side_t           dv_side_r [NW+1];
  logic [NW-1:0]      dva_n_r   [NW+1];
  logic [QW-1:0]      dva_den_r [NW+1];
  logic [QW-1:0]      dva_rem_r [NW+1];
  logic [NW-1:0]      dva_quo_r [NW+1];
  logic [NW-1:0]      dvb_n_r   [NW+1];
  logic [QW-1:0]      dvb_den_r [NW+1];
  logic [QW-1:0]      dvb_rem_r [NW+1];
  logic [NW-1:0]      dvb_quo_r [NW+1];

  logic               fin_v_r;
  logic signed [63:0] fin_t0_r;
  logic signed [63:0] fin_t1_r;
  logic               fin_miss_r;
  logic signed [31:0] fin_tmax_r;

  logic               out_v_r;
  rsi_out_t           out_r;
  logic               skid_v_r;
  rsi_out_t           skid_r;

  // Pipeline holds as one while the skid register is full
  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;
  assign out_fire = out_v_r && !out_stall;

  // -------------------------------------------------------------------------
  // Valid bits
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      p2_v_r  <= 1'b0;
      p3_v_r  <= 1'b0;
      p4_v_r  <= 1'b0;
      p5_v_r  <= 1'b0;
      p6_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r  <= in_valid;
      p2_v_r  <= p1_v_r;
      p3_v_r  <= p2_v_r;
      p4_v_r  <= p3_v_r;
      p5_v_r  <= p4_v_r;
      p6_v_r  <= p5_v_r;
      fin_v_r <= dv_v_r[NW];
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1: capture, L = O - C
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_d_r[0] <= in_data.dir_x;
      p1_d_r[1] <= in_data.dir_y;
      p1_d_r[2] <= in_data.dir_z;
      p1_l_r[0] <= 33'(in_data.origin_x) - 33'(in_data.center_x);
      p1_l_r[1] <= 33'(in_data.origin_y) - 33'(in_data.center_y);
      p1_l_r[2] <= 33'(in_data.origin_z) - 33'(in_data.center_z);
      p1_r_r    <= in_data.radius;
      p1_tmax_r <= in_data.max_distance;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: component products
  // -------------------------------------------------------------------------
  logic signed [63:0] dd_full [3];
  logic signed [64:0] dl_full [3];
  logic signed [65:0] ll_full [3];
  logic [61:0]        rr_full;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_full[i] = p1_d_r[i] * p1_d_r[i];
      dl_full[i] = p1_d_r[i] * p1_l_r[i];
      ll_full[i] = p1_l_r[i] * p1_l_r[i];
    end
    rr_full = p1_r_r * p1_r_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p2_dd_r[i] <= dd_full[i][62:0];
        p2_dl_r[i] <= dl_full[i];
        p2_ll_r[i] <= ll_full[i][64:0];
      end
      p2_rr_r   <= rr_full;
      p2_tmax_r <= p1_tmax_r;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: scale each term down by FRAC_BITS (floor) and sum
  // -------------------------------------------------------------------------
  logic [AW-1:0]        a_nxt;
  logic signed [HW-1:0] h_nxt;
  logic [CW-1:0]        c_nxt;

  always_comb begin
    a_nxt = '0;
    h_nxt = '0;
    c_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      a_nxt = a_nxt + AW'(p2_dd_r[i] >> F);
      h_nxt = h_nxt + HW'(p2_dl_r[i] >>> F);
      c_nxt = c_nxt + CW'(p2_ll_r[i] >> F);
    end
    c_nxt = c_nxt - CW'(p2_rr_r >> F);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_a_r    <= a_nxt;
      p3_h_r    <= h_nxt;
      p3_c_r    <= signed'(c_nxt);
      p3_tmax_r <= p2_tmax_r;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 4: magnitudes and signs
  // -------------------------------------------------------------------------
  logic signed [HW-1:0] h_abs;
  logic signed [CW-1:0] c_abs;
  sq_side_t             p4_side_nxt;

  always_comb begin
    h_abs = p3_h_r[HW-1] ? -p3_h_r : p3_h_r;
    c_abs = p3_c_r[CW-1] ? -p3_c_r : p3_c_r;
    p4_side_nxt.hm    = h_abs[HMW-1:0];
    p4_side_nxt.hpos  = !p3_h_r[HW-1] && (p3_h_r != '0);
    p4_side_nxt.cm    = c_abs[CMW-1:0];
    p4_side_nxt.cneg  = p3_c_r[CW-1];
    p4_side_nxt.czero = (p3_c_r == '0);
    p4_side_nxt.a     = p3_a_r;
    p4_side_nxt.miss  = (p3_a_r == '0);
    p4_side_nxt.dzero = 1'b0;
    p4_side_nxt.tmax  = p3_tmax_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_side_r <= p4_side_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 5: 32-bit partial products of h*h and a*|c|
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      p5_side_r <= p4_side_r;
      p5_hll_r  <= p4_side_r.hm[31:0] * p4_side_r.hm[31:0];
      p5_hlh_r  <= p4_side_r.hm[31:0] * p4_side_r.hm[HMW-1:32];
      p5_hhh_r  <= p4_side_r.hm[HMW-1:32] * p4_side_r.hm[HMW-1:32];
      p5_all_r  <= p4_side_r.a[31:0] * p4_side_r.cm[31:0];
      p5_alh_r  <= p4_side_r.a[31:0] * p4_side_r.cm[CMW-1:32];
      p5_ahl_r  <= p4_side_r.a[AW-1:32] * p4_side_r.cm[31:0];
      p5_ahh_r  <= p4_side_r.a[AW-1:32] * p4_side_r.cm[CMW-1:32];
    end
  end

  // -------------------------------------------------------------------------
  // Stage 6: sum partial products
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      p6_side_r <= p5_side_r;
      p6_hh_r   <= DW'(p5_hll_r) + (DW'(p5_hlh_r) << 33) + (DW'(p5_hhh_r) << 64);
      p6_ac_r   <= DW'(p5_all_r) + (DW'(p5_alh_r) << 32) + (DW'(p5_ahl_r) << 32)
                 + (DW'(p5_ahh_r) << 64);
    end
  end

  // -------------------------------------------------------------------------
  // Stage 7: discriminant h*h - a*c, miss when negative
  // -------------------------------------------------------------------------
  logic [DW:0]   disc_diff;
  logic [DW-1:0] disc_nxt;
  logic          c_le0;
  sq_side_t      sq0_side_nxt;

  always_comb begin
    c_le0     = p6_side_r.cneg || p6_side_r.czero;
    disc_diff = {1'b0, p6_hh_r} - {1'b0, p6_ac_r};
    disc_nxt  = c_le0 ? (p6_hh_r + p6_ac_r) : disc_diff[DW-1:0];
    sq0_side_nxt       = p6_side_r;
    sq0_side_nxt.miss  = p6_side_r.miss || (!c_le0 && disc_diff[DW]);
    sq0_side_nxt.dzero = (disc_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= p6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side_r[0] <= sq0_side_nxt;
      sq_rad_r[0]  <= (2*SW)'(disc_nxt);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  // -------------------------------------------------------------------------
  // Square root: one root bit per stage, two radicand bits brought down
  // -------------------------------------------------------------------------
  for (genvar k = 0; k < SW; k++) begin : g_sq
    logic [SW+1:0] rem_sh;
    logic [SW+1:0] trial;
    logic          take;

    always_comb begin
      rem_sh = {sq_rem_r[k][SW-1:0], sq_rad_r[k][2*SW-1 -: 2]};
      trial  = {sq_root_r[k], 2'b01};
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_side_r[k+1] <= sq_side_r[k];
        sq_rad_r[k+1]  <= sq_rad_r[k] << 2;
        sq_rem_r[k+1]  <= take ? (rem_sh - trial) : rem_sh;
        sq_root_r[k+1] <= {sq_root_r[k][SW-2:0], take};
      end
    end
  end

  // -------------------------------------------------------------------------
  // q stage: |q| = |h| + s, load both dividers
  // -------------------------------------------------------------------------
  logic [QW-1:0] qm_nxt;
  dv_side_t      dv0_side_nxt;

  always_comb begin
    qm_nxt = QW'(sq_side_r[SW].hm) + QW'(sq_root_r[SW]);
    dv0_side_nxt.t0neg = sq_side_r[SW].hpos;
    dv0_side_nxt.t1neg = sq_side_r[SW].cneg ^ sq_side_r[SW].hpos;
    dv0_side_nxt.czero = sq_side_r[SW].czero;
    dv0_side_nxt.dzero = sq_side_r[SW].dzero;
    dv0_side_nxt.miss  = sq_side_r[SW].miss;
    dv0_side_nxt.tmax  = sq_side_r[SW].tmax;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side_r[0] <= dv0_side_nxt;
      dva_n_r[0]   <= {qm_nxt, {F{1'b0}}};
      dva_den_r[0] <= QW'(sq_side_r[SW].a);
      dva_rem_r[0] <= '0;
      dva_quo_r[0] <= '0;
      dvb_n_r[0]   <= {QW'(sq_side_r[SW].cm), {F{1'b0}}};
      dvb_den_r[0] <= qm_nxt;
      dvb_rem_r[0] <= '0;
      dvb_quo_r[0] <= '0;
    end
  end

  // -------------------------------------------------------------------------
  // Restoring division: q/a and c/q, one quotient bit per stage
  // -------------------------------------------------------------------------
  for (genvar j = 0; j < NW; j++) begin : g_dv
    logic [QW:0] ra_sh;
    logic [QW:0] rb_sh;
    logic [QW:0] ra_sub;
    logic [QW:0] rb_sub;
    logic        ta;
    logic        tb;

    always_comb begin
      ra_sh  = {dva_rem_r[j], dva_n_r[j][NW-1]};
      rb_sh  = {dvb_rem_r[j], dvb_n_r[j][NW-1]};
      ra_sub = ra_sh - {1'b0, dva_den_r[j]};
      rb_sub = rb_sh - {1'b0, dvb_den_r[j]};
      ta     = (ra_sh >= {1'b0, dva_den_r[j]});
      tb     = (rb_sh >= {1'b0, dvb_den_r[j]});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side_r[j+1] <= dv_side_r[j];
        dva_n_r[j+1]   <= dva_n_r[j] << 1;
        dva_den_r[j+1] <= dva_den_r[j];
        dva_rem_r[j+1] <= ta ? ra_sub[QW-1:0] : ra_sh[QW-1:0];
        dva_quo_r[j+1] <= {dva_quo_r[j][NW-2:0], ta};
        dvb_n_r[j+1]   <= dvb_n_r[j] << 1;
        dvb_den_r[j+1] <= dvb_den_r[j];
        dvb_rem_r[j+1] <= tb ? rb_sub[QW-1:0] : rb_sh[QW-1:0];
        dvb_quo_r[j+1] <= {dvb_quo_r[j][NW-2:0], tb};
      end
    end
  end

  // -------------------------------------------------------------------------
  // Root select: cap magnitudes, apply signs, pick t1 for the special cases
  // -------------------------------------------------------------------------
  logic [62:0]        m0;
  logic [62:0]        m1;
  logic signed [63:0] t0_nxt;
  logic signed [63:0] t1_nxt;

  always_comb begin
    m0     = (dva_quo_r[NW] > CAP_Q) ? CAP_Q[62:0] : dva_quo_r[NW][62:0];
    m1     = (dvb_quo_r[NW] > CAP_Q) ? CAP_Q[62:0] : dvb_quo_r[NW][62:0];
    t0_nxt = dv_side_r[NW].t0neg ? -$signed({1'b0, m0}) : $signed({1'b0, m0});
    if (dv_side_r[NW].dzero) begin
      t1_nxt = t0_nxt;
    end else if (dv_side_r[NW].czero) begin
      t1_nxt = '0;
    end else begin
      t1_nxt = dv_side_r[NW].t1neg ? -$signed({1'b0, m1}) : $signed({1'b0, m1});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_t0_r   <= t0_nxt;
      fin_t1_r   <= t1_nxt;
      fin_miss_r <= dv_side_r[NW].miss;
      fin_tmax_r <= dv_side_r[NW].tmax;
    end
  end

  // -------------------------------------------------------------------------
  // Nearest root, range test against max distance, saturate
  // -------------------------------------------------------------------------
  logic signed [63:0] tmin;
  logic signed [63:0] tsat;
  logic               hit_nxt;
  rsi_out_t           res;

  always_comb begin
    tmin    = (fin_t1_r < fin_t0_r) ? fin_t1_r : fin_t0_r;
    hit_nxt = !fin_miss_r && !(tmin > 64'(fin_tmax_r));
    if (tmin > DIST_MAX) begin
      tsat = DIST_MAX;
    end else if (tmin < DIST_MIN) begin
      tsat = DIST_MIN;
    end else begin
      tsat = tmin;
    end
    res.hit          = hit_nxt;
    res.hit_distance = hit_nxt ? tsat[31:0] : '0;
  end

  // -------------------------------------------------------------------------
  // Output register and skid: absorb one result while out is stalled
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (fin_v_r) begin
      if (!out_v_r || out_fire) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (fin_v_r) begin
      if (!out_v_r || out_fire) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
